@@ rtl/core/kal_pkg.sv @@
// kal_pkg: shared types and constants of the scalar kalman estimator
// used by kal_div and scalar_kalman_estimator; no dependencies
`default_nettype none

package kal_pkg;

  // field and datapath widths
  localparam int unsigned MeasW  = 32;
  localparam int unsigned EstW   = 48;
  localparam int unsigned GainW  = 31;
  localparam int unsigned CovW   = 32;
  localparam int unsigned DenW   = CovW + 1;
  localparam int unsigned DiffW  = EstW + 1;
  localparam int unsigned QuotW  = GainW;
  localparam int unsigned CntW   = 5;
  localparam int unsigned CfgIdxW = 1;

  // q2.30 constants
  localparam logic [GainW-1:0] OneQ30  = 31'h4000_0000;
  localparam logic [29:0]      HalfQ30 = 30'h2000_0000;

  // register reset values
  localparam logic [CovW-1:0] ProcNoiseRst = 32'd10737;
  localparam logic [CovW-1:0] MeasNoiseRst = 32'd107374182;
  localparam logic [CovW-1:0] CovRst       = 32'h4000_0000;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PROCESS_NOISE     = 1'b0,
    REG_MEASUREMENT_NOISE = 1'b1
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED,
    ST_DEN,
    ST_DIV,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_STEP,
    ST_UPD
  } st_e;

  // divider request and response
  typedef struct packed {
    logic            start;
    logic [CovW-1:0] p1;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/scalar_kalman_estimator.sv @@
// scalar_kalman_estimator: top level of the one-dimensional kalman estimator
// depends on kal_pkg and kal_div
`default_nettype none

// One measurement in, one result out (estimate Q32.16, gain Q1.30, covariance
// Q2.30). An item passes from its transfer to its result through prediction
// (ST_PRED, ST_DEN), the bit-serial gain divider, three passes through the
// shared 32x32 multiplier, and rounding and update (ST_STEP, ST_UPD). The input
// is ready only between items; a finished result waits in the output register
// while the next measurement is taken, and the next result is held back until
// the previous one has been transferred. The user must write noise registers
// through the plain write port only while the block is idle; it is not enforced.
module scalar_kalman_estimator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [kal_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [kal_pkg::CovW-1:0]          cfg_wdata_i,
  // measurement channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [kal_pkg::MeasW-1:0]  measurement_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [kal_pkg::EstW-1:0]        estimate_o,
  output logic [kal_pkg::GainW-1:0]              gain_o,
  output logic [kal_pkg::CovW-1:0]               covariance_o
);

  localparam int unsigned MeasW = kal_pkg::MeasW;
  localparam int unsigned EstW  = kal_pkg::EstW;
  localparam int unsigned GainW = kal_pkg::GainW;
  localparam int unsigned CovW  = kal_pkg::CovW;
  localparam int unsigned DenW  = kal_pkg::DenW;
  localparam int unsigned DiffW = kal_pkg::DiffW;

  kal_pkg::st_e state_q, state_d;

  // registers
  logic [CovW-1:0]          q_noise_q, r_noise_q;
  logic [EstW-1:0]          est_q;
  logic [CovW-1:0]          cov_q;
  logic                     out_valid_q;
  logic [GainW-1:0]         gain_out_q;

  // working registers
  logic [MeasW-1:0]         meas_q;
  logic [CovW-1:0]          p1_q;
  logic [DenW-1:0]          den_q;
  logic [DiffW-1:0]         diff_q;
  logic                     neg_q;
  logic [EstW-1:0]          mag_q;
  logic [GainW-1:0]         gain_q;
  logic [54:0]              a_q, b_q;
  logic [62:0]              c_q;
  logic [55:0]              rest_q;
  logic [DiffW-1:0]         step_q;
  logic [CovW-1:0]          pnew_q;

  // combinational signals
  logic                     in_xfer, commit;
  logic [CovW:0]            p1_sum;
  logic [CovW-1:0]          p1_d;
  logic [DenW-1:0]          den_d;
  logic [DiffW-1:0]         diff_d;
  logic [DiffW-1:0]         neg_diff;
  logic [31:0]              mul_a, mul_b;
  logic [63:0]              prod;
  logic [55:0]              rest_d;
  logic [DiffW-1:0]         step_d;
  logic [63:0]              c_round;
  logic [33:0]              pnew_full;
  logic [EstW+1:0]          xn_wide;
  logic [EstW-1:0]          xn;
  logic                     div_start;
  kal_pkg::div_req_t        div_req;
  kal_pkg::div_rsp_t        div_rsp;

  // gain divider
  kal_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_xfer = in_valid_i && in_ready_o;
  assign commit  = (state_q == kal_pkg::ST_UPD) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kal_pkg::ST_IDLE:  if (in_valid_i) state_d = kal_pkg::ST_PRED;
      kal_pkg::ST_PRED:  state_d = kal_pkg::ST_DEN;
      kal_pkg::ST_DEN:   state_d = kal_pkg::ST_DIV;
      kal_pkg::ST_DIV:   if (div_rsp.done) state_d = kal_pkg::ST_MUL_A;
      kal_pkg::ST_MUL_A: state_d = kal_pkg::ST_MUL_B;
      kal_pkg::ST_MUL_B: state_d = kal_pkg::ST_MUL_C;
      kal_pkg::ST_MUL_C: state_d = kal_pkg::ST_STEP;
      kal_pkg::ST_STEP:  state_d = kal_pkg::ST_UPD;
      kal_pkg::ST_UPD:   if (commit) state_d = kal_pkg::ST_IDLE;
      default:           state_d = kal_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, divider start, multiplier operands
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      kal_pkg::ST_IDLE:  in_ready_o = 1'b1;
      kal_pkg::ST_DEN:   div_start = 1'b1;
      kal_pkg::ST_MUL_A: begin
        mul_a = {8'b0, mag_q[EstW-1:24]};
        mul_b = {1'b0, gain_q};
      end
      kal_pkg::ST_MUL_B: begin
        mul_a = {8'b0, mag_q[23:0]};
        mul_b = {1'b0, gain_q};
      end
      kal_pkg::ST_MUL_C: begin
        mul_a = {1'b0, kal_pkg::OneQ30 - gain_q};
        mul_b = p1_q;
      end
      default: ;
    endcase
  end

  // prediction: clamped covariance, innovation, denominator and negated innovation
  always_comb begin
    p1_sum = {1'b0, cov_q} + {1'b0, q_noise_q};
    p1_d   = p1_sum[CovW] ? '1 : p1_sum[CovW-1:0];
    diff_d = {{(DiffW-MeasW-16){meas_q[MeasW-1]}}, meas_q, 16'b0}
           - {est_q[EstW-1], est_q};
    den_d  = {1'b0, p1_q} + {1'b0, r_noise_q};
    neg_diff = -diff_q;
  end

  assign div_req.start = div_start;
  assign div_req.p1    = p1_q;
  assign div_req.den   = den_d;

  // shared multiplier
  assign prod = mul_a * mul_b;

  // rounding of the scaled step and of the new covariance
  always_comb begin
    rest_d    = {26'b0, a_q[5:0], 24'b0} + {1'b0, b_q} + {26'b0, kal_pkg::HalfQ30};
    step_d    = a_q[54:6] + {23'b0, rest_q[55:30]};
    c_round   = {1'b0, c_q} + {34'b0, kal_pkg::HalfQ30};
    pnew_full = c_round[63:30];
  end

  // estimate update with saturation guard
  always_comb begin
    if (neg_q) begin
      xn_wide = {{2{est_q[EstW-1]}}, est_q} - {1'b0, step_q};
    end else begin
      xn_wide = {{2{est_q[EstW-1]}}, est_q} + {1'b0, step_q};
    end
    if (!xn_wide[EstW+1] && (xn_wide[EstW:EstW-1] != 2'b00)) begin
      xn = {1'b0, {(EstW-1){1'b1}}};
    end else if (xn_wide[EstW+1] && (xn_wide[EstW:EstW-1] != 2'b11)) begin
      xn = {1'b1, {(EstW-1){1'b0}}};
    end else begin
      xn = xn_wide[EstW-1:0];
    end
  end

  // control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kal_pkg::ST_IDLE;
      q_noise_q   <= kal_pkg::ProcNoiseRst;
      r_noise_q   <= kal_pkg::MeasNoiseRst;
      est_q       <= '0;
      cov_q       <= kal_pkg::CovRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kal_pkg::REG_PROCESS_NOISE:     q_noise_q <= cfg_wdata_i;
          kal_pkg::REG_MEASUREMENT_NOISE: r_noise_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (commit) begin
        est_q       <= xn;
        cov_q       <= pnew_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) meas_q <= measurement_i;
    case (state_q)
      kal_pkg::ST_PRED: begin
        p1_q   <= p1_d;
        diff_q <= diff_d;
      end
      kal_pkg::ST_DEN: begin
        den_q <= den_d;
        neg_q <= diff_q[DiffW-1];
        mag_q <= diff_q[DiffW-1] ? neg_diff[EstW-1:0] : diff_q[EstW-1:0];
      end
      kal_pkg::ST_DIV: begin
        if (div_rsp.done) gain_q <= (den_q == '0) ? '0 : div_rsp.quot;
      end
      kal_pkg::ST_MUL_A: a_q <= prod[54:0];
      kal_pkg::ST_MUL_B: b_q <= prod[54:0];
      kal_pkg::ST_MUL_C: begin
        c_q    <= prod[62:0];
        rest_q <= rest_d;
      end
      kal_pkg::ST_STEP: begin
        step_q <= step_d;
        pnew_q <= (pnew_full[33:32] != 2'b00) ? '1 : pnew_full[CovW-1:0];
      end
      default: ;
    endcase
    if (commit) gain_out_q <= gain_q;
  end

  assign out_valid_o  = out_valid_q;
  assign estimate_o   = est_q;
  assign gain_o       = gain_out_q;
  assign covariance_o = cov_q;

endmodule

`default_nettype wire

@@ rtl/core/kal_div.sv @@
// kal_div: radix-2 restoring divider computing floor(p1 * 2^30 / den)
// one quotient bit per cycle; uses kal_pkg
`default_nettype none

module kal_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire kal_pkg::div_req_t req_i,
  output kal_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned DenW  = kal_pkg::DenW;
  localparam int unsigned QuotW = kal_pkg::QuotW;
  localparam int unsigned CntW  = kal_pkg::CntW;
  localparam int unsigned CovW  = kal_pkg::CovW;

  logic              busy_q, done_q;
  logic [CntW-1:0]   cnt_q;
  logic [DenW-1:0]   rem_q, den_q;
  logic [QuotW-1:0]  lo_q, quot_q;

  logic [DenW:0]     shifted;
  logic [DenW:0]     sub;
  logic              ge;

  // trial subtraction of one step
  always_comb begin
    shifted = {rem_q, lo_q[QuotW-1]};
    sub     = shifted - {1'b0, den_q};
    ge      = (shifted >= {1'b0, den_q});
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QuotW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder starts at p1 >> 1, remaining dividend bits are {p1[0], 30 zeros}
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= {2'b00, req_i.p1[CovW-1:1]};
      lo_q   <= {req_i.p1[0], {(QuotW-1){1'b0}}};
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? sub[DenW-1:0] : shifted[DenW-1:0];
      lo_q   <= {lo_q[QuotW-2:0], 1'b0};
      quot_q <= {quot_q[QuotW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire
